[hw/rtl/qph_pkg.sv]
// Shared widths, constants and payload types of the quadratic probing hash insert block.
package qph_pkg;

    localparam int KEY_W  = 31;
    localparam int SIZE_W = 11;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last_key;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  probe_count;
        logic              inserted;
        logic              batch_end;
    } t_out;

endpackage

[hw/rtl/qph_mod_unit.sv]
// Shared add and single modular reduction unit, used for division steps and probe steps.
module qph_mod_unit (
    input  logic [qph_pkg::SIZE_W-1:0] i_a,
    input  logic [qph_pkg::SIZE_W-1:0] i_b,
    input  logic                       i_cin,
    input  logic [qph_pkg::SIZE_W-1:0] i_n,
    output logic [qph_pkg::SIZE_W-1:0] o_r
);

    logic [qph_pkg::SIZE_W:0] sum;
    logic [qph_pkg::SIZE_W:0] n_ext;
    logic [qph_pkg::SIZE_W:0] diff;

    // Both operands are below the modulus, so one subtraction suffices.
    // A modulus of one always reduces to zero.
    always_comb begin
        sum   = {1'b0, i_a} + {1'b0, i_b} + {{qph_pkg::SIZE_W{1'b0}}, i_cin};
        n_ext = {1'b0, i_n};
        diff  = sum - n_ext;
        if (i_n == qph_pkg::SIZE_W'(1)) begin
            o_r = '0;
        end else if (sum >= n_ext) begin
            o_r = diff[qph_pkg::SIZE_W-1:0];
        end else begin
            o_r = sum[qph_pkg::SIZE_W-1:0];
        end
    end

endmodule

[hw/rtl/qph_slot_mem.sv]
// Slot occupancy and stored key memories with one write port and one registered read port.
module qph_slot_mem #(
    parameter int SLOTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(SLOTS)-1:0]    i_waddr,
    input  logic                        i_wused,
    input  logic [qph_pkg::KEY_W-1:0]   i_wkey,
    input  logic [$clog2(SLOTS)-1:0]    i_raddr,
    output logic                        o_rd_used
);

    logic                      r_used_mem [SLOTS];
    logic [qph_pkg::KEY_W-1:0] r_key_mem  [SLOTS];
    logic                      r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_used_mem[i_waddr] <= i_wused;
            r_key_mem[i_waddr]  <= i_wkey;
        end
        r_rd_used <= r_used_mem[i_raddr];
    end

    assign o_rd_used = r_rd_used;

endmodule

[hw/rtl/quadratic_probe_hash_insert_top.sv]
// Top level of the quadratic probing hash insert block: sequencer, configuration and result.
//
// After reset the block clears every slot of the occupancy memory and holds busy high
// throughout; configuration writes are still taken then. An item is taken when start is high
// and busy is low. The home slot is found by a restoring division of the 31-bit key by the
// effective table size, one key bit per cycle through the shared add-and-reduce unit. Each
// probe then reads the occupancy memory through its registered port and checks the bit and
// steps the shared unit to the next quadratic offset, up to as many probes as the effective
// table size when the table is full. Busy stays high from the taking of an item until its
// last probe; its result is shown in the cycle that follows, in which the next item can
// already be taken. The result appears on o_result for exactly one cycle, flagged by
// o_valid; the receiver cannot stall it, so it must take every result in the cycle it is
// shown. A table size of zero behaves as one and a size above SLOTS behaves as SLOTS.
// The table size should only be rewritten while the block is idle; the stored occupancy
// is kept across such a change.
module quadratic_probe_hash_insert_top #(
    parameter int SLOTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  qph_pkg::t_in               i_item,
    output logic                       busy,
    output logic                       o_valid,
    output qph_pkg::t_out              o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [qph_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    localparam int KEY_BIT_W = $clog2(qph_pkg::KEY_W);

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [qph_pkg::SIZE_W-1:0]  r_table_size;
    logic [qph_pkg::SIZE_W-1:0]  r_n;
    logic [qph_pkg::KEY_W-1:0]   r_key;
    logic                        r_last;
    logic [KEY_BIT_W-1:0]        r_bit;
    logic [qph_pkg::SIZE_W-1:0]  r_t;
    logic [qph_pkg::SIZE_W-1:0]  r_d;
    logic [qph_pkg::CNT_W:0]     r_cnt;
    logic [AW-1:0]               r_clr;
    logic                        r_valid;
    qph_pkg::t_out               r_result;

    logic [qph_pkg::SIZE_W-1:0]  n_eff;
    logic [31:0]                 ts_wide;
    logic [qph_pkg::SIZE_W-1:0]  unit_a;
    logic [qph_pkg::SIZE_W-1:0]  unit_b;
    logic                        unit_cin;
    logic [qph_pkg::SIZE_W-1:0]  unit_r;
    logic [AW+qph_pkg::SIZE_W-1:0] t_ext;
    logic [AW-1:0]               t_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic                        mem_wused;
    logic                        rd_used;
    logic                        last_probe;
    logic [qph_pkg::CNT_W:0]     cnt_inc;

    // The effective table size clamps the register to the range one to SLOTS.
    assign ts_wide = 32'(r_table_size);
    always_comb begin
        if (r_table_size == '0) begin
            n_eff = qph_pkg::SIZE_W'(1);
        end else if (ts_wide > 32'(SLOTS)) begin
            n_eff = qph_pkg::SIZE_W'(SLOTS);
        end else begin
            n_eff = r_table_size;
        end
    end

    // The slot register is always below the table size, which never exceeds SLOTS.
    assign t_ext  = (AW + qph_pkg::SIZE_W)'(r_t);
    assign t_addr = t_ext[AW-1:0];

    // The probe sequence has reached its last offset once the count equals the table size.
    assign last_probe = (r_cnt == {1'b0, r_n});
    assign cnt_inc    = r_cnt + (qph_pkg::CNT_W + 1)'(1);

    // Operand selection for the shared unit. During division it doubles the partial
    // remainder and brings in the next key bit. In the read cycle it advances the odd
    // increment by two, and in the check cycle it adds that increment to the slot, which
    // together walk home + j*j without a multiplier.
    always_comb begin
        unit_a   = r_t;
        unit_b   = r_d;
        unit_cin = 1'b0;
        unique case (r_state) inside
            S_DIV: begin
                unit_a   = r_t;
                unit_b   = r_t;
                unit_cin = r_key[r_bit];
            end
            S_RD: begin
                unit_a = r_d;
                unit_b = qph_pkg::SIZE_W'(2);
            end
            S_CHK: begin
                unit_a = r_t;
                unit_b = r_d;
            end
            S_CLEAR, S_IDLE: begin
                unit_a = r_t;
                unit_b = r_d;
            end
            default: begin
                unit_a = r_t;
                unit_b = r_d;
            end
        endcase
    end

    qph_mod_unit u_mod (
        .i_a   (unit_a),
        .i_b   (unit_b),
        .i_cin (unit_cin),
        .i_n   (r_n),
        .o_r   (unit_r)
    );

    // Memory writes: the clearing sweep after reset, and the claim of a free slot.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = t_addr;
        mem_wused = 1'b1;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wused = 1'b0;
        end else if (r_state == S_CHK && !rd_used) begin
            mem_we = 1'b1;
        end
    end

    qph_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wused   (mem_wused),
        .i_wkey    (r_key),
        .i_raddr   (t_addr),
        .o_rd_used (rd_used)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!rd_used || last_probe) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_table_size <= qph_pkg::TABLE_SIZE_RESET;
            r_clr        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end

            if (r_state == S_CHK && (!rd_used || last_probe)) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_key <= i_item.key;
                    r_last <= i_item.last_key;
                    r_n   <= n_eff;
                    r_bit <= KEY_BIT_W'(qph_pkg::KEY_W - 1);
                    r_t   <= '0;
                end
            end
            S_DIV: begin
                r_t   <= unit_r;
                r_bit <= r_bit - KEY_BIT_W'(1);
                if (r_bit == '0) begin
                    // The increment starts one step behind so that the first read
                    // cycle brings it to one.
                    r_d   <= r_n - qph_pkg::SIZE_W'(1);
                    r_cnt <= (qph_pkg::CNT_W + 1)'(1);
                end
            end
            S_RD: begin
                r_d <= unit_r;
            end
            S_CHK: begin
                if (!rd_used) begin
                    r_result.slot        <= r_t[qph_pkg::SLOT_W-1:0];
                    r_result.probe_count <= r_cnt[qph_pkg::CNT_W-1:0];
                    r_result.inserted    <= 1'b1;
                    r_result.batch_end   <= r_last;
                end else if (last_probe) begin
                    r_result.slot        <= '0;
                    r_result.probe_count <= cnt_inc[qph_pkg::CNT_W-1:0];
                    r_result.inserted    <= 1'b0;
                    r_result.batch_end   <= r_last;
                end else begin
                    r_t   <= unit_r;
                    r_cnt <= cnt_inc;
                end
            end
            S_CLEAR: begin
                r_t <= '0;
            end
            default: begin
                r_t <= '0;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule
